[sv/tacm_pkg.sv]
// ----------------------------------------------------------------------------
// tacm_pkg
// Shared widths, register indexes, reset values and job type for the touch
// averaging and calibration map block.
// ----------------------------------------------------------------------------
`default_nettype none

package tacm_pkg;

    localparam int COORD_W     = 12;
    localparam int SUM_W       = 16;
    localparam int COUNT_W     = 5;
    localparam int DIV_W       = 2 * COORD_W;
    localparam int REG_INDEX_W = 3;

    localparam int DEFAULT_AVERAGE_SAMPLES = 8;

    typedef logic [REG_INDEX_W-1:0] reg_index_t;

    localparam reg_index_t REG_CAL_MIN_X = 3'd0;
    localparam reg_index_t REG_CAL_MAX_X = 3'd1;
    localparam reg_index_t REG_CAL_MIN_Y = 3'd2;
    localparam reg_index_t REG_CAL_MAX_Y = 3'd3;
    localparam reg_index_t REG_RES_X     = 3'd4;
    localparam reg_index_t REG_RES_Y     = 3'd5;
    localparam reg_index_t REG_ROTATED   = 3'd6;

    localparam logic [COORD_W-1:0] RST_CAL_MIN = 12'd200;
    localparam logic [COORD_W-1:0] RST_CAL_MAX = 12'd3900;
    localparam logic [COORD_W-1:0] RST_RES_X   = 12'd320;
    localparam logic [COORD_W-1:0] RST_RES_Y   = 12'd240;

    typedef struct packed {
        logic [SUM_W-1:0]   sum;
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
        logic [COORD_W-1:0] res;
        logic               invert;
    } axis_job_t;

endpackage

`default_nettype wire

[sv/tacm_div.sv]
// ----------------------------------------------------------------------------
// tacm_div
// Bit-serial restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tacm_div (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tacm_pkg::DIV_W-1:0]   dividend,
    input  wire logic [tacm_pkg::COORD_W-1:0] divisor,
    output logic                            done,
    output logic [tacm_pkg::DIV_W-1:0]        quotient
);
    import tacm_pkg::*;

    localparam int CNT_W = $clog2(DIV_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DIV_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   quo_reg;
    logic [COORD_W-1:0] rem_reg;
    logic [COORD_W-1:0] div_reg;
    logic [COORD_W:0]   shifted;
    logic [COORD_W:0]   diff;
    logic               ge;

    assign shifted = {rem_reg, quo_reg[DIV_W-1]};
    assign ge      = shifted >= {1'b0, div_reg};
    assign diff    = shifted - {1'b0, div_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_LAST;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= '0;
            div_reg <= divisor;
        end
        else if (busy_reg)
        begin
            quo_reg <= {quo_reg[DIV_W-2:0], ge};
            rem_reg <= ge ? diff[COORD_W-1:0] : shifted[COORD_W-1:0];
        end
    end

    assign done     = done_reg;
    assign quotient = quo_reg;

endmodule

`default_nettype wire

[sv/tacm_mul.sv]
// ----------------------------------------------------------------------------
// tacm_mul
// Shift-add multiplier, one multiplier bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module tacm_mul (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire logic [tacm_pkg::COORD_W-1:0] mcand,
    input  wire logic [tacm_pkg::COORD_W-1:0] mplier,
    output logic                            done,
    output logic [tacm_pkg::DIV_W-1:0]        product
);
    import tacm_pkg::*;

    localparam int CNT_W = $clog2(COORD_W);
    localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(COORD_W - 1);

    logic               busy_reg;
    logic               done_reg;
    logic [CNT_W-1:0]   cnt_reg;
    logic [DIV_W-1:0]   acc_reg;
    logic [COORD_W-1:0] mcand_reg;
    logic [COORD_W:0]   partial;

    assign partial = {1'b0, acc_reg[DIV_W-1:COORD_W]}
                   + (acc_reg[0] ? {1'b0, mcand_reg} : '0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= CNT_LAST;
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - 1'b1;
            if (cnt_reg == '0)
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            acc_reg   <= {{COORD_W{1'b0}}, mplier};
            mcand_reg <= mcand;
        end
        else if (busy_reg)
        begin
            acc_reg <= {partial, acc_reg[COORD_W-1:1]};
        end
    end

    assign done    = done_reg;
    assign product = acc_reg;

endmodule

`default_nettype wire

[sv/tacm_axis.sv]
// ----------------------------------------------------------------------------
// tacm_axis
// One axis: average by serial division, clamp, serial multiply by the
// resolution, serial divide by the window span, optional inversion.
// ----------------------------------------------------------------------------
`default_nettype none

module tacm_axis #(
    parameter int AVERAGE_SAMPLES = tacm_pkg::DEFAULT_AVERAGE_SAMPLES
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    input  wire tacm_pkg::axis_job_t          job,
    output logic                            done,
    output logic [tacm_pkg::COORD_W-1:0]      result
);
    import tacm_pkg::*;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_AVG  = 2'd1;
    localparam logic [1:0] ST_MUL  = 2'd2;
    localparam logic [1:0] ST_MAP  = 2'd3;

    localparam logic [COORD_W-1:0] AVG_DIVISOR = COORD_W'(AVERAGE_SAMPLES);

    logic [1:0]         state_reg;
    logic [1:0]         state_next;
    logic               done_reg;
    logic [COORD_W-1:0] result_reg;
    axis_job_t          job_reg;

    logic               div_start;
    logic [DIV_W-1:0]   div_dividend;
    logic [COORD_W-1:0] div_divisor;
    logic               div_done;
    logic [DIV_W-1:0]   div_quo;
    logic               mul_start;
    logic               mul_done;
    logic [DIV_W-1:0]   mul_prod;

    logic [SUM_W-1:0]   avg;
    logic [SUM_W-1:0]   lo_w;
    logic [SUM_W-1:0]   hi_w;
    logic [SUM_W-1:0]   low_clamped;
    logic [SUM_W-1:0]   clamped;
    logic [COORD_W-1:0] offset;
    logic [COORD_W-1:0] span;
    logic [COORD_W-1:0] quo;
    logic               empty;
    logic [COORD_W-1:0] mapped;

    assign avg         = div_quo[SUM_W-1:0];
    assign lo_w        = {{(SUM_W-COORD_W){1'b0}}, job_reg.lo};
    assign hi_w        = {{(SUM_W-COORD_W){1'b0}}, job_reg.hi};
    assign low_clamped = (avg < lo_w) ? lo_w : avg;
    assign clamped     = (low_clamped > hi_w) ? hi_w : low_clamped;
    assign offset      = clamped[COORD_W-1:0] - job_reg.lo;
    assign span        = job_reg.hi - job_reg.lo;
    assign quo         = div_quo[COORD_W-1:0];
    assign empty       = job_reg.hi <= job_reg.lo;

    always_comb
    begin
        if (empty)
            mapped = job_reg.invert ? job_reg.res : '0;
        else if (job_reg.invert)
            mapped = job_reg.res - quo;
        else
            mapped = quo;
    end

    assign div_start    = ((state_reg == ST_IDLE) && start)
                        || ((state_reg == ST_MUL) && mul_done);
    assign div_dividend = (state_reg == ST_IDLE)
                        ? {{(DIV_W-SUM_W){1'b0}}, job.sum} : mul_prod;
    assign div_divisor  = (state_reg == ST_IDLE) ? AVG_DIVISOR : span;
    assign mul_start    = (state_reg == ST_AVG) && div_done;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (start)    state_next = ST_AVG;
            ST_AVG:  if (div_done) state_next = ST_MUL;
            ST_MUL:  if (mul_done) state_next = ST_MAP;
            ST_MAP:  if (div_done) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            done_reg  <= (state_reg == ST_MAP) && div_done;
        end
    end

    always_ff @(posedge clk)
    begin
        if ((state_reg == ST_IDLE) && start)
            job_reg <= job;
        if ((state_reg == ST_MAP) && div_done)
            result_reg <= mapped;
    end

    tacm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quotient (div_quo)
    );

    tacm_mul u_mul (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (mul_start),
        .mcand   (offset),
        .mplier  (job_reg.res),
        .done    (mul_done),
        .product (mul_prod)
    );

    assign done   = done_reg;
    assign result = result_reg;

endmodule

`default_nettype wire

[sv/touch_average_calibrate_map.sv]
// ----------------------------------------------------------------------------
// touch_average_calibrate_map
// Averages pressed touch samples, clamps each axis to its calibration window
// and maps it onto the screen resolution; a release repeats the last point.
// ----------------------------------------------------------------------------
// channel   handshake               payload
// input     in_valid / in_ready     raw_x, raw_y, pressed
// output    out_valid / out_ready   out_x, out_y, held
// config    cfg_we                  cfg_index, cfg_data
//
// a pressed sample that does not complete the average is added to the sums
// the completing sample starts both axes: per axis a 24-step serial
// divider runs twice around a 12-step serial multiplier
// a release emits the held point
// reset clears configuration to defaults, sums, count and the last point
// input stalls while a point is being computed or the output is full and not taken
// ----------------------------------------------------------------------------
`default_nettype none

module touch_average_calibrate_map #(
    parameter int AVERAGE_SAMPLES = tacm_pkg::DEFAULT_AVERAGE_SAMPLES
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           in_valid,
    output logic                                in_ready,
    input  wire logic [tacm_pkg::COORD_W-1:0]     raw_x,
    input  wire logic [tacm_pkg::COORD_W-1:0]     raw_y,
    input  wire logic                           pressed,
    output logic                                out_valid,
    input  wire logic                           out_ready,
    output logic [tacm_pkg::COORD_W-1:0]          out_x,
    output logic [tacm_pkg::COORD_W-1:0]          out_y,
    output logic                                held,
    input  wire logic                           cfg_we,
    input  wire logic [tacm_pkg::REG_INDEX_W-1:0] cfg_index,
    input  wire logic [tacm_pkg::COORD_W-1:0]     cfg_data
);
    import tacm_pkg::*;

    localparam logic [COUNT_W-1:0] COUNT_TARGET = COUNT_W'(AVERAGE_SAMPLES);

    logic [COORD_W-1:0] cal_min_x_reg;
    logic [COORD_W-1:0] cal_max_x_reg;
    logic [COORD_W-1:0] cal_min_y_reg;
    logic [COORD_W-1:0] cal_max_y_reg;
    logic [COORD_W-1:0] res_x_reg;
    logic [COORD_W-1:0] res_y_reg;
    logic               rotated_reg;

    logic [SUM_W-1:0]   sum_x_reg;
    logic [SUM_W-1:0]   sum_y_reg;
    logic [COUNT_W-1:0] count_reg;
    logic [COORD_W-1:0] last_x_reg;
    logic [COORD_W-1:0] last_y_reg;
    logic               busy_reg;
    logic               pend_reg;
    logic               out_valid_reg;
    logic [COORD_W-1:0] out_x_reg;
    logic [COORD_W-1:0] out_y_reg;
    logic               held_reg;

    logic               slot_free;
    logic               in_fire;
    logic [SUM_W-1:0]   sum_x_next;
    logic [SUM_W-1:0]   sum_y_next;
    logic [COUNT_W-1:0] count_next;
    logic               last_sample;
    logic               launch;
    logic               load_result;
    axis_job_t          job_x;
    axis_job_t          job_y;
    logic [1:0]         ax_done;
    logic [COORD_W-1:0] ax_x;
    logic [COORD_W-1:0] ax_y;

    assign slot_free   = !out_valid_reg || out_ready;
    assign in_ready    = !busy_reg && slot_free;
    assign in_fire     = in_valid && in_ready;
    assign sum_x_next  = sum_x_reg + {{(SUM_W-COORD_W){1'b0}}, raw_x};
    assign sum_y_next  = sum_y_reg + {{(SUM_W-COORD_W){1'b0}}, raw_y};
    assign count_next  = count_reg + 1'b1;
    assign last_sample = count_next >= COUNT_TARGET;
    assign launch      = in_fire && pressed && last_sample;
    assign load_result = pend_reg && slot_free;

    always_comb
    begin
        job_x.sum    = rotated_reg ? sum_y_next : sum_x_next;
        job_x.lo     = rotated_reg ? cal_min_y_reg : cal_min_x_reg;
        job_x.hi     = rotated_reg ? cal_max_y_reg : cal_max_x_reg;
        job_x.res    = res_x_reg;
        job_x.invert = 1'b0;
        job_y.sum    = rotated_reg ? sum_x_next : sum_y_next;
        job_y.lo     = rotated_reg ? cal_min_x_reg : cal_min_y_reg;
        job_y.hi     = rotated_reg ? cal_max_x_reg : cal_max_y_reg;
        job_y.res    = res_y_reg;
        job_y.invert = rotated_reg;
    end

    // configuration
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cal_min_x_reg <= RST_CAL_MIN;
            cal_max_x_reg <= RST_CAL_MAX;
            cal_min_y_reg <= RST_CAL_MIN;
            cal_max_y_reg <= RST_CAL_MAX;
            res_x_reg     <= RST_RES_X;
            res_y_reg     <= RST_RES_Y;
            rotated_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_CAL_MIN_X: cal_min_x_reg <= cfg_data;
                REG_CAL_MAX_X: cal_max_x_reg <= cfg_data;
                REG_CAL_MIN_Y: cal_min_y_reg <= cfg_data;
                REG_CAL_MAX_Y: cal_max_y_reg <= cfg_data;
                REG_RES_X:     res_x_reg     <= cfg_data;
                REG_RES_Y:     res_y_reg     <= cfg_data;
                REG_ROTATED:   rotated_reg   <= cfg_data[0];
                default:       ;
            endcase
        end
    end

    // accumulation and result control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_x_reg     <= '0;
            sum_y_reg     <= '0;
            count_reg     <= '0;
            last_x_reg    <= '0;
            last_y_reg    <= '0;
            busy_reg      <= 1'b0;
            pend_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                if (!pressed || last_sample)
                begin
                    sum_x_reg <= '0;
                    sum_y_reg <= '0;
                    count_reg <= '0;
                end
                else
                begin
                    sum_x_reg <= sum_x_next;
                    sum_y_reg <= sum_y_next;
                    count_reg <= count_next;
                end
            end

            if (launch)
                busy_reg <= 1'b1;
            else if (load_result)
                busy_reg <= 1'b0;

            if (ax_done[0] && ax_done[1])
                pend_reg <= 1'b1;
            else if (load_result)
                pend_reg <= 1'b0;

            if (load_result)
            begin
                last_x_reg <= ax_x;
                last_y_reg <= ax_y;
            end

            if ((in_fire && !pressed) || load_result)
                out_valid_reg <= 1'b1;
            else if (out_ready)
                out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_fire && !pressed)
        begin
            out_x_reg <= last_x_reg;
            out_y_reg <= last_y_reg;
            held_reg  <= 1'b1;
        end
        else if (load_result)
        begin
            out_x_reg <= ax_x;
            out_y_reg <= ax_y;
            held_reg  <= 1'b0;
        end
    end

    tacm_axis #(
        .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
    ) u_axis_x (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (launch),
        .job    (job_x),
        .done   (ax_done[0]),
        .result (ax_x)
    );

    tacm_axis #(
        .AVERAGE_SAMPLES (AVERAGE_SAMPLES)
    ) u_axis_y (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (launch),
        .job    (job_y),
        .done   (ax_done[1]),
        .result (ax_y)
    );

    assign out_valid = out_valid_reg;
    assign out_x     = out_x_reg;
    assign out_y     = out_y_reg;
    assign held      = held_reg;

endmodule

`default_nettype wire

[sv/tacm_checker.sv]
// ----------------------------------------------------------------------------
// tacm_checker
// Port-level checks on request flow and held-point repeats.
// ----------------------------------------------------------------------------
`default_nettype none

module tacm_checker (
    input wire logic                       clk,
    input wire logic                       rst_n,
    input wire logic                       in_valid,
    input wire logic                       in_ready,
    input wire logic                       pressed,
    input wire logic                       out_valid,
    input wire logic                       out_ready,
    input wire logic [tacm_pkg::COORD_W-1:0] out_x,
    input wire logic [tacm_pkg::COORD_W-1:0] out_y,
    input wire logic                       held
);

    // stalled result stays put
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_x) && $stable(out_y)
            && $stable(held))
        else $error("output changed while stalled");

    // full output blocks new requests
    a_full_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |-> !in_ready)
        else $error("input accepted while output full");

    // release answers in the next cycle, flagged
    a_release_held: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && !pressed |=> out_valid && held)
        else $error("release not answered with held point");

    // a fresh held result always comes from a release
    a_held_source: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && held && !$past(out_valid && !out_ready)
            |-> $past(in_valid && in_ready && !pressed))
        else $error("held result without release");

endmodule

bind touch_average_calibrate_map tacm_checker u_tacm_checker (.*);

`default_nettype wire

[sim/touch_average_calibrate_map_test.sv]
// ----------------------------------------------------------------------------
// touch_average_calibrate_map_test
// Self-checking bench for the touch averaging and calibration map block.
// A scoreboard tracks the running sums, the calibration registers and the
// last point, and predicts every emitted point. Requests come with random
// gaps and random output back-pressure, including one long output stall.
// The calibration is changed between phases, with extreme, empty and rotated
// settings among them.
// ----------------------------------------------------------------------------
module touch_average_calibrate_map_test;
    timeunit 1ns;
    timeprecision 1ps;

    import tacm_pkg::*;

    localparam int SAMPLES       = DEFAULT_AVERAGE_SAMPLES;
    localparam int REG_COUNT     = int'(REG_ROTATED) + 1;
    localparam int SETTLE_CYCLES = 100;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 6;
    localparam int PHASE_ITEMS   = 64;
    localparam int HOLD_CYCLES   = 400;
    localparam int IDLE_PERCENT  = 37;

    typedef struct packed {
        logic [COORD_W-1:0] x;
        logic [COORD_W-1:0] y;
        logic               held;
    } screen_point_t;

    class point_tracker;
        logic [COORD_W-1:0] lo_x = RST_CAL_MIN;
        logic [COORD_W-1:0] hi_x = RST_CAL_MAX;
        logic [COORD_W-1:0] lo_y = RST_CAL_MIN;
        logic [COORD_W-1:0] hi_y = RST_CAL_MAX;
        logic [COORD_W-1:0] width_px = RST_RES_X;
        logic [COORD_W-1:0] height_px = RST_RES_Y;
        logic               rotate = 1'b0;
        logic [SUM_W-1:0]   acc_x = '0;
        logic [SUM_W-1:0]   acc_y = '0;
        logic [COUNT_W-1:0] gathered = '0;
        screen_point_t      last_point = '0;
        screen_point_t      pending_points[$];
        int                 errors = 0;

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        function void set_reg(reg_index_t idx, logic [COORD_W-1:0] value);
            case (idx)
                REG_CAL_MIN_X: lo_x = value;
                REG_CAL_MAX_X: hi_x = value;
                REG_CAL_MIN_Y: lo_y = value;
                REG_CAL_MAX_Y: hi_y = value;
                REG_RES_X:     width_px = value;
                REG_RES_Y:     height_px = value;
                REG_ROTATED:   rotate = value[0];
                default:       ;
            endcase
        endfunction

        function logic [COORD_W-1:0] scale_axis(input logic [COORD_W-1:0] avg, lo, hi, res,
                                                input logic invert);
            int unsigned offset;
            int unsigned span;
            int unsigned quot;
            if (hi <= lo)
                return invert ? res : '0;
            offset = (avg < lo) ? 0 : (avg > hi) ? hi - lo : avg - lo;
            span = hi - lo;
            quot = offset * res / span;
            return invert ? COORD_W'(res - quot) : COORD_W'(quot);
        endfunction

        function void note_sample(input logic [COORD_W-1:0] sx, sy, input logic down);
            screen_point_t      repeat_point;
            logic [COORD_W-1:0] avg_x;
            logic [COORD_W-1:0] avg_y;
            if (!down) begin
                acc_x = '0;
                acc_y = '0;
                gathered = '0;
                repeat_point = last_point;
                repeat_point.held = 1'b1;
                pending_points.push_back(repeat_point);
                return;
            end
            acc_x += sx;
            acc_y += sy;
            gathered++;
            if (gathered < SAMPLES)
                return;
            avg_x = COORD_W'(acc_x / SAMPLES);
            avg_y = COORD_W'(acc_y / SAMPLES);
            acc_x = '0;
            acc_y = '0;
            gathered = '0;
            if (rotate) begin
                last_point.x = scale_axis(avg_y, lo_y, hi_y, width_px, 1'b0);
                last_point.y = scale_axis(avg_x, lo_x, hi_x, height_px, 1'b1);
            end
            else begin
                last_point.x = scale_axis(avg_x, lo_x, hi_x, width_px, 1'b0);
                last_point.y = scale_axis(avg_y, lo_y, hi_y, height_px, 1'b0);
            end
            last_point.held = 1'b0;
            pending_points.push_back(last_point);
        endfunction

        task check_point(screen_point_t seen);
            screen_point_t want;
            if (pending_points.size() == 0) begin
                report($sformatf("unexpected point x=%0d y=%0d held=%0b",
                                 seen.x, seen.y, seen.held));
                return;
            end
            want = pending_points.pop_front();
            if (seen.x != want.x)
                report($sformatf("out_x %0d, expected %0d", seen.x, want.x));
            if (seen.y != want.y)
                report($sformatf("out_y %0d, expected %0d", seen.y, want.y));
            if (seen.held != want.held)
                report($sformatf("held %0b, expected %0b", seen.held, want.held));
        endtask
    endclass

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic               in_ready;
    logic [COORD_W-1:0] raw_x = '0;
    logic [COORD_W-1:0] raw_y = '0;
    logic               pressed = 1'b0;
    logic               out_valid;
    logic               out_ready = 1'b0;
    logic [COORD_W-1:0] out_x;
    logic [COORD_W-1:0] out_y;
    logic               held;
    logic               cfg_we = 1'b0;
    reg_index_t         cfg_index = REG_CAL_MIN_X;
    logic [COORD_W-1:0] cfg_data = '0;

    logic               steady = 1'b0;
    logic               stall_go = 1'b0;
    logic               hold_off = 1'b0;
    int                 cycles = 0;
    logic [COORD_W-1:0] setting [REG_COUNT];
    point_tracker       board = new;

    touch_average_calibrate_map dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .raw_x     (raw_x),
        .raw_y     (raw_y),
        .pressed   (pressed),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_x     (out_x),
        .out_y     (out_y),
        .held      (held),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles == CYCLE_LIMIT)
        begin
            $display("touch_average_calibrate_map_test failed");
            $finish;
        end
    end

    initial
    begin
        @(posedge rst_n);
        forever
        begin
            @(posedge clk);
            if (out_valid && out_ready)
                board.check_point('{out_x, out_y, held});
            out_ready <= !hold_off && (steady || $urandom_range(99) >= IDLE_PERCENT);
        end
    end

    // long output stall while requests keep coming
    initial
    begin
        wait (stall_go);
        hold_off <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_off <= 1'b0;
    end

    task send_sample(input logic [COORD_W-1:0] sx, sy, input logic down);
        while (!steady && $urandom_range(99) < IDLE_PERCENT)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        raw_x <= sx;
        raw_y <= sy;
        pressed <= down;
        do @(posedge clk); while (!in_ready);
        board.note_sample(sx, sy, down);
    endtask

    task drain();
        in_valid <= 1'b0;
        while (board.pending_points.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task apply_setting();
        for (int i = REG_CAL_MIN_X; i <= REG_ROTATED; i++)
        begin
            cfg_we <= 1'b1;
            cfg_index <= reg_index_t'(i);
            cfg_data <= setting[i];
            @(posedge clk);
            board.set_reg(reg_index_t'(i), setting[i]);
        end
        cfg_we <= 1'b0;
    endtask

    task pick_setting(int phase);
        int lo;
        int hi;
        case (phase)
            0:
            begin
                setting[REG_CAL_MIN_X] = '0;
                setting[REG_CAL_MAX_X] = '1;
                setting[REG_CAL_MIN_Y] = '0;
                setting[REG_CAL_MAX_Y] = '1;
                setting[REG_RES_X]     = '1;
                setting[REG_RES_Y]     = '1;
                setting[REG_ROTATED]   = 12'd0;
            end
            // inverted and empty windows, zero width
            1:
            begin
                setting[REG_CAL_MIN_X] = '1;
                setting[REG_CAL_MAX_X] = '0;
                setting[REG_CAL_MIN_Y] = 12'd2048;
                setting[REG_CAL_MAX_Y] = 12'd2048;
                setting[REG_RES_X]     = '0;
                setting[REG_RES_Y]     = '1;
                setting[REG_ROTATED]   = 12'd1;
            end
            default:
            begin
                for (int i = REG_CAL_MIN_X; i <= REG_CAL_MAX_Y; i += 2)
                begin
                    lo = $urandom_range(2047);
                    hi = $urandom_range(4095, lo + 1);
                    if ($urandom_range(7) == 0)
                    begin
                        lo = $urandom_range(4095);
                        hi = $urandom_range(4095);
                    end
                    setting[i] = COORD_W'(lo);
                    setting[i + 1] = COORD_W'(hi);
                end
                setting[REG_RES_X]   = COORD_W'($urandom_range(4095));
                setting[REG_RES_Y]   = COORD_W'($urandom_range(4095));
                setting[REG_ROTATED] = COORD_W'($urandom_range(1));
            end
        endcase
    endtask

    function logic [COORD_W-1:0] near(int center);
        int v;
        v = center + $urandom_range(64) - 32;
        return COORD_W'((v < 0) ? 0 : (v > 4095) ? 4095 : v);
    endfunction

    initial
    begin
        int roll;
        int cx;
        int cy;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // release with nothing gathered, then full scale, alternating bits, partial set
        send_sample('0, '0, 1'b0);
        repeat (SAMPLES) send_sample('1, '1, 1'b1);
        repeat (SAMPLES / 2) send_sample(12'hAAA, 12'h555, 1'b1);
        repeat (SAMPLES / 2) send_sample(12'h555, 12'hAAA, 1'b1);
        repeat (3) send_sample(12'd2048, 12'd1024, 1'b1);
        send_sample(12'd100, 12'd3000, 1'b0);
        drain();

        for (int phase = 0; phase < RANDOM_PHASES; phase++)
        begin
            pick_setting(phase);
            apply_setting();
            steady <= (phase == 2);
            if (phase == 3)
                stall_go <= 1'b1;
            cx = $urandom_range(4095);
            cy = $urandom_range(4095);
            for (int n = 0; n < PHASE_ITEMS; n++)
            begin
                roll = $urandom_range(99);
                if (roll < 8)
                begin
                    send_sample(COORD_W'($urandom), COORD_W'($urandom), 1'b0);
                    cx = $urandom_range(4095);
                    cy = $urandom_range(4095);
                end
                else if (roll < 30)
                    send_sample(COORD_W'($urandom), COORD_W'($urandom), 1'b1);
                else
                    send_sample(near(cx), near(cy), 1'b1);
            end
            drain();
        end

        if (board.pending_points.size() != 0)
            board.report("points still expected at end of run");
        if (board.errors == 0)
            $display("touch_average_calibrate_map_test passed");
        else
            $display("touch_average_calibrate_map_test failed");
        $finish;
    end

endmodule

[sim.f]
sv/tacm_pkg.sv
sv/tacm_div.sv
sv/tacm_mul.sv
sv/tacm_axis.sv
sv/touch_average_calibrate_map.sv
sv/tacm_checker.sv
sim/touch_average_calibrate_map_test.sv
